[rtl/rdfe_pkg.sv]
package rdfe_pkg;

  localparam int IN_WIDTH        = 55;
  localparam int MOD_WIDTH       = 10;
  localparam int IDX_WIDTH       = 5;
  localparam int CODE_WIDTH      = 8;
  localparam int PACK_WIDTH      = 60;
  localparam int NUM_PACKS       = 4;
  localparam int FIELDS_PER_PACK = 6;
  localparam int NUM_MODULI      = NUM_PACKS * FIELDS_PER_PACK;
  localparam int CFG_ADDR_WIDTH  = 3;

  // digit split and fp8 layout
  localparam int DIGIT_BITS = 4;
  localparam int EXP_BIAS   = 7;
  localparam int MANT_BITS  = 3;
  localparam int EXP_WIDTH  = CODE_WIDTH - 1 - MANT_BITS;

  // remainder loop: bits of the magnitude consumed per cycle
  localparam int STEP_BITS      = 8;
  localparam int NUM_STEPS      = (IN_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int SHIFT_WIDTH    = NUM_STEPS * STEP_BITS;
  localparam int STEP_CNT_WIDTH = $clog2(NUM_STEPS);

  localparam logic [PACK_WIDTH-1:0] PACK_RESET  = 60'd289639126768289025;
  localparam logic [IDX_WIDTH-1:0]  COUNT_RESET = 5'd1;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_COUNT  = 3'd0,
    REG_PACK_0 = 3'd1,
    REG_PACK_1 = 3'd2,
    REG_PACK_2 = 3'd3,
    REG_PACK_3 = 3'd4
  } cfg_reg_t;

  typedef logic [NUM_MODULI-1:0][MOD_WIDTH-1:0] moduli_t;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic                 fix;
    logic                 emit;
    logic                 last;
    logic [IDX_WIDTH-1:0] mod_index;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

[rtl/rdfe_elem_if.sv]
interface rdfe_elem_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rdfe_pkg::IN_WIDTH-1:0]   scaled_value;

  modport source (output valid, output scaled_value, input ready);
  modport sink   (input valid, input scaled_value, output ready);
endinterface

[rtl/rdfe_result_if.sv]
interface rdfe_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [rdfe_pkg::IDX_WIDTH-1:0]        modulus_index;
  logic signed [rdfe_pkg::MOD_WIDTH-1:0] residue;
  logic [rdfe_pkg::CODE_WIDTH-1:0]       low_digit_code;
  logic [rdfe_pkg::CODE_WIDTH-1:0]       high_digit_code;
  logic                                  last_of_run;

  modport source (output valid, output modulus_index, output residue,
                  output low_digit_code, output high_digit_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input modulus_index, input residue,
                  input low_digit_code, input high_digit_code,
                  input last_of_run, output ready);
endinterface

[rtl/rdfe_cfg_if.sv]
interface rdfe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rdfe_pkg::CFG_ADDR_WIDTH-1:0] index;
  logic [rdfe_pkg::PACK_WIDTH-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/residue_digit_fp8_encoder.sv]
// Residue digit encoder. Each accepted element word (a 55-bit two's
// complement integer) yields one result word for every modulus in use, in
// index order: the symmetric residue, its low base-16 digit and the bits
// above it as fp8 e4m3 bytes, and a last flag on the final one. A count of
// zero takes the element and gives nothing. Each modulus runs the remainder
// loop, which folds 8 bits of the 55-bit magnitude (zero-padded to 56 bits)
// into the running remainder per cycle, then a fix step that folds and
// centers the residue, then an emit step that encodes the digits into the
// output register and waits while the result side stalls. An element
// holds the block until its last result is emitted; the next element is
// taken as soon as the last result sits in the output register.
// Configuration is taken in every cycle and must change only while idle.
module residue_digit_fp8_encoder #(
  parameter int MAX_MODULI = 24
) (
  input logic           clk,
  input logic           rst,
  rdfe_elem_if.sink     element,
  rdfe_result_if.source result,
  rdfe_cfg_if.sink      regs
);

  // moduli in use, already saturated
  logic [rdfe_pkg::IDX_WIDTH-1:0] count_sat;
  rdfe_pkg::moduli_t              moduli;

  // controller to datapath
  rdfe_pkg::cmd_t                 cmd;
  rdfe_pkg::status_t              status;

  // register file for the count and the four modulus packs
  rdfe_cfg #(
    .MAX_MODULI (MAX_MODULI)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (regs.valid),
    .wr_ready  (regs.ready),
    .wr_index  (regs.index),
    .wr_data   (regs.data),
    .count_sat (count_sat),
    .moduli    (moduli)
  );

  // sequencer: walks moduli and remainder steps
  rdfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (element.valid),
    .in_ready (element.ready),
    .count    (count_sat),
    .status   (status),
    .cmd      (cmd)
  );

  // remainder loop, residue fold, digit encode and output register
  rdfe_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_value      (element.scaled_value),
    .moduli        (moduli),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_index     (result.modulus_index),
    .out_residue   (result.residue),
    .out_low_code  (result.low_digit_code),
    .out_high_code (result.high_digit_code),
    .out_last      (result.last_of_run)
  );

  // results only carry indexes of moduli in use
  a_index_in_use: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.modulus_index < count_sat)
    else $error("result index beyond moduli in use");

  // last flag sits on the final modulus only
  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.last_of_run ==
                      (result.modulus_index == count_sat - rdfe_pkg::IDX_WIDTH'(1))))
    else $error("last flag on wrong modulus");

  // zero residue gives zero digit bytes
  a_zero_codes: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.residue == '0 |->
      result.low_digit_code == '0 && result.high_digit_code == '0)
    else $error("nonzero digit code for zero residue");

  // an element with moduli in use holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    element.valid && element.ready && count_sat != '0 |=> !element.ready)
    else $error("element taken while previous still at work");

endmodule

[rtl/rdfe_cfg.sv]
module rdfe_cfg #(
  parameter int MAX_MODULI = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_valid,
  output logic                                wr_ready,
  input  logic [rdfe_pkg::CFG_ADDR_WIDTH-1:0] wr_index,
  input  logic [rdfe_pkg::PACK_WIDTH-1:0]     wr_data,
  output logic [rdfe_pkg::IDX_WIDTH-1:0]      count_sat,
  output rdfe_pkg::moduli_t                   moduli
);

  logic [rdfe_pkg::IDX_WIDTH-1:0]  count;
  logic [rdfe_pkg::PACK_WIDTH-1:0] pack [rdfe_pkg::NUM_PACKS];

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= rdfe_pkg::COUNT_RESET;
      for (int p = 0; p < rdfe_pkg::NUM_PACKS; p++) begin
        pack[p] <= rdfe_pkg::PACK_RESET;
      end
    end else if (wr_valid) begin
      unique case (rdfe_pkg::cfg_reg_t'(wr_index))
        rdfe_pkg::REG_COUNT:  count   <= wr_data[rdfe_pkg::IDX_WIDTH-1:0];
        rdfe_pkg::REG_PACK_0: pack[0] <= wr_data;
        rdfe_pkg::REG_PACK_1: pack[1] <= wr_data;
        rdfe_pkg::REG_PACK_2: pack[2] <= wr_data;
        rdfe_pkg::REG_PACK_3: pack[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // count saturates at the number of modulus slots built
  assign count_sat = (count > rdfe_pkg::IDX_WIDTH'(MAX_MODULI)) ?
                     rdfe_pkg::IDX_WIDTH'(MAX_MODULI) : count;

  always_comb begin
    for (int p = 0; p < rdfe_pkg::NUM_PACKS; p++) begin
      for (int f = 0; f < rdfe_pkg::FIELDS_PER_PACK; f++) begin
        moduli[p * rdfe_pkg::FIELDS_PER_PACK + f] =
          pack[p][f * rdfe_pkg::MOD_WIDTH +: rdfe_pkg::MOD_WIDTH];
      end
    end
  end

endmodule

[rtl/rdfe_ctrl.sv]
module rdfe_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rdfe_pkg::IDX_WIDTH-1:0] count,
  input  rdfe_pkg::status_t              status,
  output rdfe_pkg::cmd_t                 cmd
);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    CALC = 4'b0010,
    FIX  = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t                                state, state_next;
  logic [rdfe_pkg::IDX_WIDTH-1:0]        mod_index, mod_index_next;
  logic [rdfe_pkg::STEP_CNT_WIDTH-1:0]   step_count, step_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      mod_index  <= '0;
      step_count <= '0;
    end else begin
      state      <= state_next;
      mod_index  <= mod_index_next;
      step_count <= step_count_next;
    end
  end

  always_comb begin
    state_next      = state;
    mod_index_next  = mod_index;
    step_count_next = step_count;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.mod_index   = mod_index;
    cmd.last        = (mod_index == count - rdfe_pkg::IDX_WIDTH'(1));
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load        = 1'b1;
          mod_index_next  = '0;
          step_count_next = '0;
          if (count != '0) state_next = CALC;
        end
      end
      CALC: begin
        cmd.step = 1'b1;
        if (step_count == rdfe_pkg::STEP_CNT_WIDTH'(rdfe_pkg::NUM_STEPS - 1)) begin
          step_count_next = '0;
          state_next      = FIX;
        end else begin
          step_count_next = step_count + rdfe_pkg::STEP_CNT_WIDTH'(1);
        end
      end
      FIX: begin
        cmd.fix    = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (cmd.last) begin
            state_next = IDLE;
          end else begin
            mod_index_next = mod_index + rdfe_pkg::IDX_WIDTH'(1);
            state_next     = CALC;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

[rtl/rdfe_dp.sv]
module rdfe_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rdfe_pkg::cmd_t                        cmd,
  output rdfe_pkg::status_t                     status,
  input  logic signed [rdfe_pkg::IN_WIDTH-1:0]  in_value,
  input  rdfe_pkg::moduli_t                     moduli,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rdfe_pkg::IDX_WIDTH-1:0]        out_index,
  output logic signed [rdfe_pkg::MOD_WIDTH-1:0] out_residue,
  output logic [rdfe_pkg::CODE_WIDTH-1:0]       out_low_code,
  output logic [rdfe_pkg::CODE_WIDTH-1:0]       out_high_code,
  output logic                                  out_last
);

  localparam int MW = rdfe_pkg::MOD_WIDTH;
  localparam int HI_WIDTH = MW - 1 - rdfe_pkg::DIGIT_BITS;

  // fp8 e4m3 byte of a digit magnitude, truncated mantissa
  function automatic logic [rdfe_pkg::CODE_WIDTH-1:0] e4m3(
    input logic sign, input logic [HI_WIDTH-1:0] mag);
    logic [$clog2(HI_WIDTH)-1:0]                  e;
    logic [HI_WIDTH+rdfe_pkg::MANT_BITS-1:0]      scaled;
    logic [rdfe_pkg::EXP_WIDTH-1:0]               exp_field;
    e = '0;
    for (int i = 0; i < HI_WIDTH; i++) begin
      if (mag[i]) e = ($clog2(HI_WIDTH))'(i);
    end
    scaled    = {mag, {rdfe_pkg::MANT_BITS{1'b0}}} >> e;
    exp_field = rdfe_pkg::EXP_WIDTH'(e) + rdfe_pkg::EXP_WIDTH'(rdfe_pkg::EXP_BIAS);
    if (mag == '0) begin
      e4m3 = '0;
    end else begin
      e4m3 = {sign, exp_field, scaled[rdfe_pkg::MANT_BITS-1:0]};
    end
  endfunction

  logic                                 neg;
  logic [rdfe_pkg::IN_WIDTH-1:0]        mag;
  logic [rdfe_pkg::SHIFT_WIDTH-1:0]     shift;
  logic [MW-1:0]                        rem;
  logic signed [MW-1:0]                 residue;

  logic [rdfe_pkg::IN_WIDTH-1:0]        in_bits, in_mag;
  logic [MW-1:0]                        modulus, half, rem_next, rem_acc;
  logic [MW:0]                          trial;
  logic [rdfe_pkg::STEP_BITS-1:0]       chunk;
  logic signed [MW:0]                   folded, centered;
  logic signed [MW-1:0]                 residue_next;
  logic [MW-1:0]                        res_mag;
  logic [rdfe_pkg::CODE_WIDTH-1:0]      low_code, high_code;

  assign in_bits = in_value;
  assign in_mag  = in_bits[rdfe_pkg::IN_WIDTH-1] ?
                   (~in_bits + rdfe_pkg::IN_WIDTH'(1)) : in_bits;

  assign modulus = moduli[cmd.mod_index];
  assign half    = modulus >> 1;
  assign chunk   = shift[rdfe_pkg::SHIFT_WIDTH-1 -: rdfe_pkg::STEP_BITS];

  // restoring remainder, one magnitude bit per compare and subtract
  always_comb begin
    rem_acc = rem;
    trial   = '0;
    for (int k = rdfe_pkg::STEP_BITS - 1; k >= 0; k--) begin
      trial = {rem_acc, chunk[k]};
      if (trial >= {1'b0, modulus}) trial = trial - {1'b0, modulus};
      rem_acc = trial[MW-1:0];
    end
    rem_next = rem_acc;
  end

  // fold negative values back, then center on zero
  always_comb begin
    folded   = (neg && rem != '0) ? $signed({1'b0, modulus - rem}) : $signed({1'b0, rem});
    centered = (folded > $signed({1'b0, half})) ? folded - $signed({1'b0, modulus}) : folded;
    residue_next = (modulus == '0) ? '0 : centered[MW-1:0];
  end

  assign res_mag   = residue[MW-1] ? (~residue + MW'(1)) : residue;
  assign low_code  = e4m3(residue[MW-1],
                          HI_WIDTH'(res_mag[rdfe_pkg::DIGIT_BITS-1:0]));
  assign high_code = e4m3(residue[MW-1],
                          res_mag[MW-2:rdfe_pkg::DIGIT_BITS]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg   <= in_bits[rdfe_pkg::IN_WIDTH-1];
      mag   <= in_mag;
      shift <= {{(rdfe_pkg::SHIFT_WIDTH-rdfe_pkg::IN_WIDTH){1'b0}}, in_mag};
      rem   <= '0;
    end else if (cmd.step) begin
      shift <= shift << rdfe_pkg::STEP_BITS;
      rem   <= rem_next;
    end else if (cmd.fix) begin
      residue <= residue_next;
      shift   <= {{(rdfe_pkg::SHIFT_WIDTH-rdfe_pkg::IN_WIDTH){1'b0}}, mag};
      rem     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index     <= cmd.mod_index;
      out_residue   <= residue;
      out_low_code  <= low_code;
      out_high_code <= high_code;
      out_last      <= cmd.last;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule
